/* rtl/core/imuoma_pkg.sv */
// Shared types and constants for the IMU offset moving-average block.
`default_nettype none

package imuoma_pkg;

    // History depth per axis (power of two) and number of axes.
    localparam int MAX_WINDOW = 256;
    localparam int AXES       = 6;
    localparam int NUM_FIELDS = 6;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W = 16;
    localparam int WIN_W    = 9;
    localparam int RUN_W    = 15;
    localparam int GRAV_W   = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Derived widths.
    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int N_W   = PTR_W + 1;
    localparam int SUM_W = SAMPLE_W + PTR_W + 1;
    localparam int MAG_W = SUM_W - 1;
    localparam int CNT_W = $clog2(MAG_W);
    localparam int ROW_W = AXES * SAMPLE_W;

    // Register reset values.
    localparam logic [WIN_W-1:0]  WIN_RESET  = WIN_W'(200);
    localparam logic [RUN_W-1:0]  RUN_RESET  = RUN_W'(1000);
    localparam logic [GRAV_W-1:0] GRAV_RESET = GRAV_W'(16384);

    // Field position of accel Z among the result fields.
    localparam int AXIS_AZ = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW  = 2'd0,
        REG_RUN     = 2'd1,
        REG_GRAVITY = 2'd2
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_START,
        ST_DIV,
        ST_FIN
    } state_t;

    // Commands from the sequencer to every axis lane.
    typedef struct packed {
        logic clear;
        logic load;
        logic start;
        logic step;
    } lane_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/imuoma_if.sv */
// Valid/ready channel interfaces: raw samples in, offsets out, register writes.
`default_nettype none

interface imuoma_in_if;
    logic                valid;
    logic                ready;
    imuoma_pkg::sample_t accel_x;
    imuoma_pkg::sample_t accel_y;
    imuoma_pkg::sample_t accel_z;
    imuoma_pkg::sample_t gyro_x;
    imuoma_pkg::sample_t gyro_y;
    imuoma_pkg::sample_t gyro_z;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    output ready);
endinterface

interface imuoma_out_if;
    logic                valid;
    logic                ready;
    imuoma_pkg::sample_t accel_x_offset;
    imuoma_pkg::sample_t accel_y_offset;
    imuoma_pkg::sample_t accel_z_offset;
    imuoma_pkg::sample_t gyro_x_bias;
    imuoma_pkg::sample_t gyro_y_bias;
    imuoma_pkg::sample_t gyro_z_bias;
    logic                run_done;

    modport source (output valid, accel_x_offset, accel_y_offset, accel_z_offset,
                    gyro_x_bias, gyro_y_bias, gyro_z_bias, run_done,
                    input ready);
    modport sink   (input valid, accel_x_offset, accel_y_offset, accel_z_offset,
                    gyro_x_bias, gyro_y_bias, gyro_z_bias, run_done,
                    output ready);
endinterface

interface imuoma_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [imuoma_pkg::CFG_IDX_W-1:0]    index;
    logic [imuoma_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/imu_offset_moving_average.sv */
// A new sample set is accepted only once the previous one has passed the divider and
//   reached the output register; the 24-step bit-serial divider (one quotient bit a
//   cycle, six lanes) sets the pace.
// An output register holds a finished result; the next sample is taken meanwhile.
// Reset: control cleared, registers to defaults, history empty via a fill count
//   (no clearing pass); a window_length write empties the history the same way.
`default_nettype none

module imu_offset_moving_average (
    input  logic             clk,
    input  logic             rst_n,
    imuoma_in_if.sink        sample,
    imuoma_out_if.source     offset,
    imuoma_cfg_if.sink       cfg
);

    localparam int SAMPLE_W = imuoma_pkg::SAMPLE_W;
    localparam int AXES     = imuoma_pkg::AXES;
    localparam int NF       = imuoma_pkg::NUM_FIELDS;
    localparam int PTR_W    = imuoma_pkg::PTR_W;
    localparam int N_W      = imuoma_pkg::N_W;
    localparam int CNT_W    = imuoma_pkg::CNT_W;
    localparam int RUN_W    = imuoma_pkg::RUN_W;

    imuoma_pkg::state_t      state_reg, state_next;
    imuoma_pkg::lane_ctrl_t  lane_ctrl;

    logic [imuoma_pkg::WIN_W-1:0]  window_reg;
    logic [RUN_W-1:0]              run_reg;
    logic [imuoma_pkg::GRAV_W-1:0] grav_reg;

    logic [PTR_W-1:0] pos_reg;
    logic [N_W-1:0]   fill_reg;
    logic [RUN_W-1:0] seen_reg, seen_next;
    logic             done_reg;
    logic [N_W-1:0]   n_reg;
    logic             old_valid_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [N_W-1:0]   n_eff;
    logic [PTR_W-1:0] leave;
    logic [RUN_W:0]   seen_plus;
    logic [RUN_W:0]   limit;
    logic             run_end;

    imuoma_pkg::sample_t sample_in  [NF];
    imuoma_pkg::sample_t sample_reg [AXES];
    imuoma_pkg::sample_t avg_all    [NF];
    imuoma_pkg::sample_t out_reg    [NF];
    logic                out_done_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] z_adj;

    logic [imuoma_pkg::ROW_W-1:0] ram_wdata, ram_rdata;

    logic in_fire, out_fire, cfg_fire, win_write, ram_we, out_load;

    assign in_fire   = sample.valid && sample.ready;
    assign out_fire  = offset.valid && offset.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign win_write = cfg_fire && (imuoma_pkg::cfg_reg_t'(cfg.index) == imuoma_pkg::REG_WINDOW);
    assign cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= imuoma_pkg::WIN_RESET;
            run_reg    <= imuoma_pkg::RUN_RESET;
            grav_reg   <= imuoma_pkg::GRAV_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (imuoma_pkg::cfg_reg_t'(cfg.index))
                imuoma_pkg::REG_WINDOW:  window_reg <= cfg.data[imuoma_pkg::WIN_W-1:0];
                imuoma_pkg::REG_RUN:     run_reg    <= cfg.data[RUN_W-1:0];
                imuoma_pkg::REG_GRAVITY: grav_reg   <= cfg.data[imuoma_pkg::GRAV_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective window, oldest slot, run counter
    always_comb
    begin
        if (window_reg == '0)
            n_eff = N_W'(1);
        else if (int'(window_reg) > imuoma_pkg::MAX_WINDOW)
            n_eff = N_W'(imuoma_pkg::MAX_WINDOW);
        else
            n_eff = N_W'(window_reg);

        leave     = pos_reg - n_eff[PTR_W-1:0];
        seen_plus = {1'b0, seen_reg} + 1'b1;
        limit     = (run_reg == '0) ? (RUN_W+1)'(1) : {1'b0, run_reg};
        run_end   = (seen_plus >= limit);
        seen_next = run_end ? '0 : seen_plus[RUN_W-1:0];
    end

    // Sample input field order
    assign sample_in[0] = sample.accel_x;
    assign sample_in[1] = sample.accel_y;
    assign sample_in[2] = sample.accel_z;
    assign sample_in[3] = sample.gyro_x;
    assign sample_in[4] = sample.gyro_y;
    assign sample_in[5] = sample.gyro_z;

    // Per-transaction bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
            seen_reg <= '0;
            done_reg <= 1'b0;
            n_reg    <= N_W'(1);
            old_valid_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (win_write)
            begin
                pos_reg  <= '0;
                fill_reg <= '0;
            end
            else if (ram_we)
            begin
                pos_reg <= pos_reg + 1'b1;
                if (fill_reg != N_W'(imuoma_pkg::MAX_WINDOW))
                    fill_reg <= fill_reg + 1'b1;
            end
            if (in_fire)
            begin
                seen_reg      <= seen_next;
                done_reg      <= run_end;
                n_reg         <= n_eff;
                old_valid_reg <= ({1'b0, leave} < fill_reg);
            end
            if (lane_ctrl.start)
                cnt_reg <= '0;
            else if (lane_ctrl.step)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Sample capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int a = 0; a < AXES; a++)
                sample_reg[a] <= sample_in[a];
        end
    end

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
            ram_wdata[a*SAMPLE_W +: SAMPLE_W] = sample_reg[a];
    end

    imuoma_window_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (leave),
        .rdata (ram_rdata)
    );

    // Axis lanes; fields beyond the axis count read zero
    for (genvar a = 0; a < NF; a++)
    begin : g_lane
        if (a < AXES)
        begin : g_used
            imuoma_div_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (lane_ctrl),
                .divisor   (n_reg),
                .sample_in (sample_reg[a]),
                .old_in    (ram_rdata[a*SAMPLE_W +: SAMPLE_W]),
                .old_valid (old_valid_reg),
                .avg       (avg_all[a])
            );
        end
        else
        begin : g_absent
            assign avg_all[a] = '0;
        end
    end

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            imuoma_pkg::ST_IDLE:  if (in_fire) state_next = imuoma_pkg::ST_LOAD;
            imuoma_pkg::ST_LOAD:  state_next = imuoma_pkg::ST_START;
            imuoma_pkg::ST_START: state_next = imuoma_pkg::ST_DIV;
            imuoma_pkg::ST_DIV:
                if (cnt_reg == CNT_W'(imuoma_pkg::MAG_W - 1))
                    state_next = imuoma_pkg::ST_FIN;
            imuoma_pkg::ST_FIN:   if (out_load) state_next = imuoma_pkg::ST_IDLE;
            default:              state_next = imuoma_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        sample.ready    = 1'b0;
        ram_we          = 1'b0;
        out_load        = 1'b0;
        lane_ctrl       = '0;
        lane_ctrl.clear = win_write;
        unique case (state_reg)
            imuoma_pkg::ST_IDLE:  sample.ready = 1'b1;
            imuoma_pkg::ST_LOAD:
            begin
                ram_we         = 1'b1;
                lane_ctrl.load = 1'b1;
            end
            imuoma_pkg::ST_START: lane_ctrl.start = 1'b1;
            imuoma_pkg::ST_DIV:   lane_ctrl.step  = 1'b1;
            imuoma_pkg::ST_FIN:   out_load = !out_valid_reg || offset.ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= imuoma_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Output register; gravity comes off accel Z at the end of a run
    assign z_adj = avg_all[imuoma_pkg::AXIS_AZ] - {1'b0, grav_reg};

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int f = 0; f < NF; f++)
                out_reg[f] <= (done_reg && f == imuoma_pkg::AXIS_AZ)
                              ? $signed(z_adj) : avg_all[f];
            out_done_reg <= done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    assign offset.valid          = out_valid_reg;
    assign offset.accel_x_offset = out_reg[0];
    assign offset.accel_y_offset = out_reg[1];
    assign offset.accel_z_offset = out_reg[2];
    assign offset.gyro_x_bias    = out_reg[3];
    assign offset.gyro_y_bias    = out_reg[4];
    assign offset.gyro_z_bias    = out_reg[5];
    assign offset.run_done       = out_done_reg;

`ifndef SYNTH
    a_accept_starts_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == imuoma_pkg::ST_LOAD)
        else $error("accepted sample did not start a window update");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= N_W'(imuoma_pkg::MAX_WINDOW))
        else $error("fill count beyond window depth");

    a_fin_waits_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == imuoma_pkg::ST_FIN && !out_load) |-> out_valid_reg)
        else $error("result held back while output register empty");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == imuoma_pkg::ST_FIN) |->
            $past(cnt_reg) == CNT_W'(imuoma_pkg::MAG_W - 1))
        else $error("divider finished after wrong step count");
`endif

endmodule

`default_nettype wire

/* rtl/core/imuoma_window_ram.sv */
// Sample history memory: one row holds one sample of every axis.
`default_nettype none

module imuoma_window_ram (
    input  logic                           clk,
    input  logic                           we,
    input  logic [imuoma_pkg::PTR_W-1:0]   waddr,
    input  logic [imuoma_pkg::ROW_W-1:0]   wdata,
    input  logic                           re,
    input  logic [imuoma_pkg::PTR_W-1:0]   raddr,
    output logic [imuoma_pkg::ROW_W-1:0]   rdata
);

    logic [imuoma_pkg::ROW_W-1:0] mem [imuoma_pkg::MAX_WINDOW];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/imuoma_div_lane.sv */
// One axis: running window sum and a bit-serial divider, one quotient bit per cycle.
`default_nettype none

module imuoma_div_lane (
    input  logic                           clk,
    input  logic                           rst_n,
    input  imuoma_pkg::lane_ctrl_t         ctrl,
    input  logic [imuoma_pkg::N_W-1:0]     divisor,
    input  imuoma_pkg::sample_t            sample_in,
    input  imuoma_pkg::sample_t            old_in,
    input  logic                           old_valid,
    output imuoma_pkg::sample_t            avg
);

    localparam int SUM_W = imuoma_pkg::SUM_W;
    localparam int MAG_W = imuoma_pkg::MAG_W;
    localparam int N_W   = imuoma_pkg::N_W;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SUM_W-1:0] sum_neg;
    logic [MAG_W-1:0]        quo_reg;      // dividend bits out at top, quotient bits in at bottom
    logic [N_W-1:0]          rem_reg;
    logic                    neg_reg;
    logic [N_W:0]            trial;
    logic                    q_bit;
    logic [N_W:0]            trial_diff;
    logic [imuoma_pkg::SAMPLE_W-1:0] q_low;

    // Window sum: new sample in, oldest sample out (empty slots count as zero)
    always_comb
    begin
        sum_next = sum_reg + SUM_W'(sample_in)
                   - (old_valid ? SUM_W'(old_in) : SUM_W'(0));
        sum_neg  = -sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.load)
        begin
            sum_reg <= sum_next;
        end
    end

    // Restoring division step on the magnitude
    always_comb
    begin
        trial      = {rem_reg, quo_reg[MAG_W-1]};
        trial_diff = trial - {1'b0, divisor};
        q_bit      = (trial >= {1'b0, divisor});
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= '0;
            neg_reg <= sum_reg[SUM_W-1];
            quo_reg <= sum_reg[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_reg[MAG_W-1:0];
        end
        else if (ctrl.step)
        begin
            rem_reg <= q_bit ? trial_diff[N_W-1:0] : trial[N_W-1:0];
            quo_reg <= {quo_reg[MAG_W-2:0], q_bit};
        end
    end

    // Sign restored on the low bits only (truncation toward zero)
    assign q_low = quo_reg[imuoma_pkg::SAMPLE_W-1:0];
    assign avg   = neg_reg ? $signed(-q_low) : $signed(q_low);

endmodule

`default_nettype wire
